### rtl/core/ctp_pkg.sv
// shared types, status codes and constant tables of the track table parser
// no dependencies
package ctp_pkg;

  localparam int HEADER_DEPTH_DEF = 65536;
  localparam int MAX_TRACKS_DEF   = 31;
  localparam int TC_W             = 6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HDR_SIZE  = 3'd1;
  localparam logic [2:0] ST_SESSIONS  = 3'd2;
  localparam logic [2:0] ST_NO_TRACKS = 3'd3;
  localparam logic [2:0] ST_TOO_MANY  = 3'd4;
  localparam logic [2:0] ST_SEQUENCE  = 3'd5;
  localparam logic [2:0] ST_EXTENT    = 3'd6;

  localparam logic [1:0] H_STORE = 2'd0;
  localparam logic [1:0] H_2336  = 2'd1;
  localparam logic [1:0] H_MODE1 = 2'd2;
  localparam logic [1:0] H_MODE2 = 2'd3;

  localparam logic [1:0] RM_2048 = 2'd0;
  localparam logic [1:0] RM_2336 = 2'd1;
  localparam logic [1:0] RM_2352 = 2'd2;

  localparam logic [31:0] EXTENT_LIMIT = 32'd1000000;
  localparam logic [31:0] NUM_LIMIT    = 32'd999;
  localparam logic [15:0] SES_LIMIT    = 16'd99;
  localparam logic [31:0] CDT_LIMIT    = 32'd4096;
  localparam logic [15:0] IC_LIMIT     = 16'd64;

  typedef struct packed {
    logic [19:0] pregap;
    logic [19:0] sectors;
    logic [6:0]  ses;
    logic [9:0]  num;
    logic [1:0]  mode;
    logic [1:0]  rm;
    logic [15:0] desc;
  } track_entry_t;

  typedef struct packed {
    logic [30:0] data_offset;
    logic [31:0] stored_size;
    logic [31:0] plain_size;
    logic [1:0]  handling;
    logic        is_pregap;
    logic [6:0]  session_index;
    logic [9:0]  track_index;
    logic [15:0] descriptor_offset;
    logic [2:0]  status;
    logic        last_item;
  } result_t;

  typedef struct packed {
    logic            done;
    logic [2:0]      status;
    logic [6:0]      sessions;
    logic [TC_W-1:0] track_count;
  } scan_status_t;

  function automatic logic [7:0] sentinel_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd2:                      b = 8'h01;
      4'd6, 4'd7, 4'd8, 4'd9:    b = 8'hff;
      default:                   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [11:0] sector_size(input logic [1:0] rm);
    logic [11:0] s;
    unique case (rm)
      RM_2048: s = 12'd2048;
      RM_2336: s = 12'd2336;
      default: s = 12'd2352;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/ctp_if.sv
// valid/ready channels of the track table parser: header bytes, results, configuration
// depends on nothing
interface ctp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       final_byte;
  modport source (output valid, output header_byte, output final_byte, input ready);
  modport sink   (input valid, input header_byte, input final_byte, output ready);
endinterface

interface ctp_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] data_offset;
  logic [31:0] stored_size;
  logic [31:0] plain_size;
  logic [1:0]  handling;
  logic        is_pregap;
  logic [6:0]  session_index;
  logic [9:0]  track_index;
  logic [15:0] descriptor_offset;
  logic [2:0]  status;
  logic        last_item;
  modport source (output valid, output data_offset, output stored_size, output plain_size,
                  output handling, output is_pregap, output session_index,
                  output track_index, output descriptor_offset, output status,
                  output last_item, input ready);
  modport sink   (input valid, input data_offset, input stored_size, input plain_size,
                  input handling, input is_pregap, input session_index,
                  input track_index, input descriptor_offset, input status,
                  input last_item, output ready);
endinterface

interface ctp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] header_position;
  modport source (output valid, output header_position, input ready);
  modport sink   (input valid, input header_position, output ready);
endinterface

### rtl/core/cdi_track_table_parser.sv
// top level of the disc image track table parser
// depends on ctp_pkg, ctp_if, ctp_header_mem, ctp_track_table, ctp_scanner, ctp_walker
module cdi_track_table_parser #(
  parameter int HEADER_DEPTH = ctp_pkg::HEADER_DEPTH_DEF,
  parameter int MAX_TRACKS   = ctp_pkg::MAX_TRACKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ctp_in_if.sink    hdr,
  ctp_out_if.source res,
  ctp_cfg_if.sink   cfg
);
  // Header bytes are taken one per cycle into a HEADER_DEPTH byte store. After
  // the byte marked final the block stops taking bytes until the run's status
  // item has been handed to the output register. The scan reads the store one
  // byte at a time through a single read port, each read passing an address
  // state and a data state. The check pass then steps each track through read,
  // entry, pregap and sector states, the emission through those and two output
  // states that wait out output stalls; each extent goes through one shared
  // 20x12 multiplier. Each result transfer leaves through one output register.
  import ctp_pkg::*;

  localparam int AW  = $clog2(HEADER_DEPTH);
  localparam int CW  = $clog2(HEADER_DEPTH + 2);
  localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  localparam logic [1:0] T_LOAD = 2'd0;
  localparam logic [1:0] T_SIZE = 2'd1;
  localparam logic [1:0] T_SCAN = 2'd2;
  localparam logic [1:0] T_WALK = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] hdr_len;
  logic [30:0]   header_position;
  logic          out_valid;
  result_t       out_reg;

  logic          in_xfer;
  logic [CW-1:0] bc_inc;
  logic          size_bad;
  logic          scan_start;
  logic          walk_start;
  logic [2:0]    walk_status;

  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          tbl_we;
  logic [TAW-1:0] tbl_waddr;
  logic [TAW-1:0] tbl_raddr;
  track_entry_t  tbl_wdata;
  track_entry_t  tbl_rdata;
  scan_status_t  scan_stat;
  logic          push_valid;
  logic          push_ready;
  result_t       push_item;
  logic          walk_done;

  assign hdr.ready = (state == T_LOAD);
  assign cfg.ready = 1'b1;
  assign in_xfer   = hdr.valid && hdr.ready;
  // count saturates one past the store depth to flag an oversized header
  assign bc_inc    = (byte_count <= CW'(HEADER_DEPTH)) ? byte_count + CW'(1) : byte_count;

  assign size_bad = (hdr_len < CW'(16)) || (hdr_len > CW'(HEADER_DEPTH)) ||
                    (header_position == 31'd0) ||
                    ({1'b0, header_position} + 32'(hdr_len) > 32'h8000_0000);

  assign scan_start  = (state == T_SIZE) && !size_bad;
  assign walk_start  = ((state == T_SIZE) && size_bad) || ((state == T_SCAN) && scan_stat.done);
  assign walk_status = (state == T_SIZE) ? ST_HDR_SIZE : scan_stat.status;
  assign push_ready  = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_LOAD;
      byte_count      <= '0;
      header_position <= 31'd1;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        header_position <= cfg.header_position;
      end
      if (push_valid && push_ready) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_LOAD: begin
          if (in_xfer) begin
            if (hdr.final_byte) begin
              hdr_len    <= bc_inc;
              byte_count <= '0;
              state      <= T_SIZE;
            end else begin
              byte_count <= bc_inc;
            end
          end
        end
        T_SIZE: state <= size_bad ? T_WALK : T_SCAN;
        T_SCAN: begin
          if (scan_stat.done) begin
            state <= T_WALK;
          end
        end
        T_WALK: begin
          if (walk_done) begin
            state <= T_LOAD;
          end
        end
        default: state <= T_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      out_reg <= push_item;
    end
  end

  assign res.valid             = out_valid;
  assign res.data_offset       = out_reg.data_offset;
  assign res.stored_size       = out_reg.stored_size;
  assign res.plain_size        = out_reg.plain_size;
  assign res.handling          = out_reg.handling;
  assign res.is_pregap         = out_reg.is_pregap;
  assign res.session_index     = out_reg.session_index;
  assign res.track_index       = out_reg.track_index;
  assign res.descriptor_offset = out_reg.descriptor_offset;
  assign res.status            = out_reg.status;
  assign res.last_item         = out_reg.last_item;

  ctp_header_mem #(.DEPTH(HEADER_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (in_xfer && (byte_count < CW'(HEADER_DEPTH))),
    .waddr (byte_count[AW-1:0]),
    .wdata (hdr.header_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ctp_track_table #(.MAX_TRACKS(MAX_TRACKS), .TAW(TAW)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ctp_scanner #(
    .DEPTH(HEADER_DEPTH), .MAX_TRACKS(MAX_TRACKS), .AW(AW), .CW(CW), .TAW(TAW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .hdr_len   (hdr_len),
    .raddr     (mem_raddr),
    .rdata     (mem_rdata),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .stat      (scan_stat)
  );

  ctp_walker #(.MAX_TRACKS(MAX_TRACKS), .TAW(TAW)) u_walk (
    .clk             (clk),
    .rst             (rst),
    .start           (walk_start),
    .start_status    (walk_status),
    .sessions        (scan_stat.sessions),
    .track_count     (scan_stat.track_count),
    .header_position (header_position),
    .tbl_raddr       (tbl_raddr),
    .tbl_rdata       (tbl_rdata),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item),
    .done            (walk_done)
  );

`ifndef SYNTH
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(HEADER_DEPTH + 1))
    else $error("byte count past saturation");
  a_push_walk: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> state == T_WALK)
    else $error("result pushed outside walk phase");
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_item.last_item |-> push_item.status == ST_OK)
    else $error("entry carries a failure status");
  a_tracks_cap: assert property (@(posedge clk) disable iff (rst)
    scan_stat.track_count <= TC_W'(MAX_TRACKS + 1))
    else $error("track count past saturation");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(push_valid))
    else $error("output valid without a push");
`endif
endmodule

### rtl/core/ctp_header_mem.sv
// header byte store: one write port, one registered read port
// depends on ctp_pkg for the default depth
module ctp_header_mem #(
  parameter int DEPTH = ctp_pkg::HEADER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/ctp_track_table.sv
// track table: one entry per accepted track block up to MAX_TRACKS, registered read
// depends on ctp_pkg
module ctp_track_table #(
  parameter int MAX_TRACKS = ctp_pkg::MAX_TRACKS_DEF,
  parameter int TAW        = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [TAW-1:0]        waddr,
  input  ctp_pkg::track_entry_t wdata,
  input  logic [TAW-1:0]        raddr,
  output ctp_pkg::track_entry_t rdata
);
  import ctp_pkg::*;

  track_entry_t mem [MAX_TRACKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/ctp_scanner.sv
// header scan sequencer: reads the session count, finds sentinel pairs, decodes
// and range checks each track block through one byte read unit; depends on ctp_pkg
module ctp_scanner #(
  parameter int DEPTH      = ctp_pkg::HEADER_DEPTH_DEF,
  parameter int MAX_TRACKS = ctp_pkg::MAX_TRACKS_DEF,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 2),
  parameter int TAW        = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CW-1:0]         hdr_len,
  output logic [AW-1:0]         raddr,
  input  logic [7:0]            rdata,
  output logic                  tbl_we,
  output logic [TAW-1:0]        tbl_waddr,
  output ctp_pkg::track_entry_t tbl_wdata,
  output ctp_pkg::scan_status_t stat
);
  import ctp_pkg::*;

  localparam int PW = ((AW > 17) ? AW : 17) + 3;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD_A = 5'd1;
  localparam logic [4:0] S_RD_D = 5'd2;
  localparam logic [4:0] S_SES  = 5'd3;
  localparam logic [4:0] S_LOOP = 5'd4;
  localparam logic [4:0] S_SENT = 5'd5;
  localparam logic [4:0] S_FNL  = 5'd6;
  localparam logic [4:0] S_ICP  = 5'd7;
  localparam logic [4:0] S_IC   = 5'd8;
  localparam logic [4:0] S_CDT  = 5'd9;
  localparam logic [4:0] S_FIX  = 5'd10;
  localparam logic [4:0] S_MODE = 5'd11;
  localparam logic [4:0] S_RM   = 5'd12;
  localparam logic [4:0] S_SESN = 5'd13;
  localparam logic [4:0] S_NUM  = 5'd14;
  localparam logic [4:0] S_PRE  = 5'd15;
  localparam logic [4:0] S_SECT = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]      state;
  logic [4:0]      ret;
  logic [PW-1:0]   first;
  logic [4:0]      k;
  logic [PW-1:0]   ra;
  logic [2:0]      rn;
  logic [1:0]      rj;
  logic [31:0]     acc;
  logic [PW-1:0]   icp;
  logic [8:0]      isz;
  logic            multi;
  logic [PW-1:0]   fixed;
  logic [1:0]      mode;
  logic [1:0]      rm;
  logic [6:0]      ses;
  logic [9:0]      num;
  logic [19:0]     pregap;
  logic [6:0]      sessions;
  logic [TC_W-1:0] tc;
  logic [2:0]      status;

  logic [PW-1:0] len;
  logic [7:0]    rbyte;
  logic [4:0]    k_mod;
  logic [PW-1:0] icp_c;
  logic [8:0]    isz_c;
  logic [12:0]   cdt;
  logic          sect_ok;

  assign len   = {{(PW-CW){1'b0}}, hdr_len};
  assign raddr = ra[AW-1:0];
  // bytes past the header read as zero
  assign rbyte = (ra < len) ? rdata : 8'h00;
  assign k_mod = (k >= 5'd10) ? k - 5'd10 : k;
  assign icp_c = first + PW'(56) + {{(PW-8){1'b0}}, acc[7:0]};
  assign isz_c = {acc[6:0], 2'b00};
  assign cdt   = acc[12:0];
  assign sect_ok = (acc != 32'd0) && (acc <= EXTENT_LIMIT);

  assign tbl_we    = (state == S_SECT) && sect_ok && (tc < TC_W'(MAX_TRACKS));
  assign tbl_waddr = tc[TAW-1:0];
  assign tbl_wdata = '{pregap: pregap, sectors: acc[19:0], ses: ses, num: num,
                       mode: mode, rm: rm, desc: first[15:0]};

  assign stat = '{done: (state == S_DONE), status: status, sessions: sessions,
                  track_count: tc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tc     <= '0;
      status <= ST_OK;
    end else begin
      if (state != S_RD_A && state != S_RD_D) begin
        rj  <= 2'd0;
        acc <= 32'd0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            first <= '0;
            tc    <= '0;
            ra    <= '0;
            rn    <= 3'd2;
            ret   <= S_SES;
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_D;
        S_RD_D: begin
          acc[{rj, 3'b000} +: 8] <= rbyte;
          if ({1'b0, rj} == rn - 3'd1) begin
            state <= ret;
          end else begin
            rj    <= rj + 2'd1;
            ra    <= ra + PW'(1);
            state <= S_RD_A;
          end
        end
        S_SES: begin
          if (acc[15:0] == 16'd0 || acc[15:0] > SES_LIMIT) begin
            status <= ST_SESSIONS;
            state  <= S_DONE;
          end else begin
            sessions <= acc[6:0];
            state    <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (first + PW'(20) > len) begin
            if (tc == '0) begin
              status <= ST_NO_TRACKS;
            end else if (tc > TC_W'(MAX_TRACKS)) begin
              status <= ST_TOO_MANY;
            end else begin
              status <= ST_OK;
            end
            state <= S_DONE;
          end else begin
            k     <= 5'd0;
            ra    <= first;
            rn    <= 3'd1;
            ret   <= S_SENT;
            state <= S_RD_A;
          end
        end
        S_SENT: begin
          if (acc[7:0] != sentinel_byte(k_mod[3:0])) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else if (k == 5'd19) begin
            state <= S_FNL;
          end else begin
            k     <= k + 5'd1;
            ra    <= first + {{(PW-5){1'b0}}, k} + PW'(1);
            rn    <= 3'd1;
            ret   <= S_SENT;
            state <= S_RD_A;
          end
        end
        S_FNL: begin
          if (first + PW'(25) > len) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            ra    <= first + PW'(24);
            rn    <= 3'd1;
            ret   <= S_ICP;
            state <= S_RD_A;
          end
        end
        S_ICP: begin
          icp <= icp_c;
          if (icp_c + PW'(2) > len) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            ra    <= icp_c;
            rn    <= 3'd2;
            ret   <= S_IC;
            state <= S_RD_A;
          end
        end
        S_IC: begin
          if (acc[15:0] == 16'd0 || acc[15:0] > IC_LIMIT ||
              icp + PW'(6) + {{(PW-9){1'b0}}, isz_c} > len) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            isz   <= isz_c;
            multi <= (acc[15:0] >= 16'd2);
            ra    <= icp + PW'(2) + {{(PW-9){1'b0}}, isz_c};
            rn    <= 3'd4;
            ret   <= S_CDT;
            state <= S_RD_A;
          end
        end
        S_CDT: begin
          if (acc > CDT_LIMIT) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            // cdt * 18 as two shifted terms
            fixed <= icp + PW'(6) + {{(PW-9){1'b0}}, isz} +
                     {{(PW-17){1'b0}}, cdt, 4'b0000} + {{(PW-14){1'b0}}, cdt, 1'b0};
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (fixed + PW'(46) > len) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            ra    <= fixed + PW'(2);
            rn    <= 3'd1;
            ret   <= S_MODE;
            state <= S_RD_A;
          end
        end
        S_MODE: begin
          if (acc[7:0] > 8'd2) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            mode  <= acc[1:0];
            ra    <= fixed + PW'(42);
            rn    <= 3'd4;
            ret   <= S_RM;
            state <= S_RD_A;
          end
        end
        S_RM: begin
          if (acc > 32'd2) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            rm    <= acc[1:0];
            ra    <= fixed + PW'(10);
            rn    <= 3'd4;
            ret   <= S_SESN;
            state <= S_RD_A;
          end
        end
        S_SESN: begin
          if (acc >= {25'd0, sessions}) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            ses   <= acc[6:0];
            ra    <= fixed + PW'(14);
            rn    <= 3'd4;
            ret   <= S_NUM;
            state <= S_RD_A;
          end
        end
        S_NUM: begin
          if (acc > NUM_LIMIT) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            num   <= acc[9:0];
            ra    <= icp + PW'(2);
            rn    <= 3'd4;
            ret   <= S_PRE;
            state <= S_RD_A;
          end
        end
        S_PRE: begin
          if (acc > EXTENT_LIMIT) begin
            first <= first + PW'(1);
            state <= S_LOOP;
          end else begin
            pregap <= acc[19:0];
            ra     <= multi ? icp + PW'(6) : fixed + PW'(22);
            rn     <= 3'd4;
            ret    <= S_SECT;
            state  <= S_RD_A;
          end
        end
        S_SECT: begin
          if (!sect_ok) begin
            first <= first + PW'(1);
          end else begin
            if (tc <= TC_W'(MAX_TRACKS)) begin
              tc <= tc + TC_W'(1);
            end
            first <= first + PW'(20);
          end
          state <= S_LOOP;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/ctp_walker.sv
// table walker: sequence, session and extent check, then entry emission, sharing one
// 20x12 multiplier for byte extents; depends on ctp_pkg
module ctp_walker #(
  parameter int MAX_TRACKS = ctp_pkg::MAX_TRACKS_DEF,
  parameter int TAW        = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0]                start_status,
  input  logic [6:0]                sessions,
  input  logic [ctp_pkg::TC_W-1:0]  track_count,
  input  logic [30:0]               header_position,
  output logic [TAW-1:0]            tbl_raddr,
  input  ctp_pkg::track_entry_t     tbl_rdata,
  output logic                      push_valid,
  input  logic                      push_ready,
  output ctp_pkg::result_t          push_item,
  output logic                      done
);
  import ctp_pkg::*;

  localparam logic [3:0] W_IDLE   = 4'd0;
  localparam logic [3:0] W_CK_RD  = 4'd1;
  localparam logic [3:0] W_CK_ENT = 4'd2;
  localparam logic [3:0] W_CK_PG  = 4'd3;
  localparam logic [3:0] W_CK_SC  = 4'd4;
  localparam logic [3:0] W_CK_END = 4'd5;
  localparam logic [3:0] W_EM_RD  = 4'd6;
  localparam logic [3:0] W_EM_ENT = 4'd7;
  localparam logic [3:0] W_EM_PG  = 4'd8;
  localparam logic [3:0] W_EM_SC  = 4'd9;
  localparam logic [3:0] W_EM_OPG = 4'd10;
  localparam logic [3:0] W_EM_OTR = 4'd11;
  localparam logic [3:0] W_STAT   = 4'd12;

  logic [3:0]      state;
  logic [TC_W-1:0] i;
  logic [6:0]      es;
  logic [9:0]      et;
  logic [37:0]     off;
  logic [2:0]      status;
  logic [31:0]     pgb;
  logic [31:0]     packed_sz;
  logic [31:0]     prod;

  logic [19:0] mul_a;
  logic [11:0] ss;
  logic        new_ses;
  logic [6:0]  es_n;
  logic [9:0]  et_n;
  logic        last_entry;

  assign tbl_raddr = i[TAW-1:0];
  assign ss        = sector_size(tbl_rdata.rm);
  assign mul_a     = (state == W_CK_ENT || state == W_EM_ENT) ? tbl_rdata.pregap
                                                              : tbl_rdata.sectors;
  assign new_ses   = (tbl_rdata.ses == es + 7'd1) && (tbl_rdata.num == 10'd0);
  assign es_n      = new_ses ? es + 7'd1 : es;
  assign et_n      = new_ses ? 10'd0 : et;
  assign last_entry = (i + TC_W'(1) == track_count);

  always_ff @(posedge clk) begin
    prod <= {12'd0, mul_a} * {20'd0, ss};
  end

  always_comb begin
    push_item  = '0;
    push_valid = 1'b0;
    unique case (state)
      W_EM_OPG: begin
        push_valid                  = (pgb != 32'd0);
        push_item.data_offset       = off[30:0];
        push_item.stored_size       = pgb;
        push_item.plain_size        = pgb;
        push_item.is_pregap         = 1'b1;
        push_item.session_index     = tbl_rdata.ses;
        push_item.track_index       = tbl_rdata.num;
        push_item.descriptor_offset = tbl_rdata.desc;
      end
      W_EM_OTR: begin
        push_valid                  = 1'b1;
        push_item.data_offset       = off[30:0];
        push_item.stored_size       = packed_sz;
        push_item.session_index     = tbl_rdata.ses;
        push_item.track_index       = tbl_rdata.num;
        push_item.descriptor_offset = tbl_rdata.desc;
        if (tbl_rdata.mode != 2'd0) begin
          // data tracks unwrap to 2048 bytes per sector
          push_item.plain_size = {1'b0, tbl_rdata.sectors, 11'd0};
          if (tbl_rdata.rm == RM_2336) begin
            push_item.handling = H_2336;
          end else if (tbl_rdata.rm == RM_2352) begin
            push_item.handling = (tbl_rdata.mode == 2'd1) ? H_MODE1 : H_MODE2;
          end else begin
            push_item.handling = H_STORE;
          end
        end else begin
          push_item.plain_size = packed_sz;
          push_item.handling   = H_STORE;
        end
      end
      W_STAT: begin
        push_valid          = 1'b1;
        push_item.status    = status;
        push_item.last_item = 1'b1;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  assign done = (state == W_STAT) && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= W_IDLE;
      status <= ST_OK;
    end else begin
      unique case (state)
        W_IDLE: begin
          if (start) begin
            status <= start_status;
            i      <= '0;
            es     <= 7'd0;
            et     <= 10'd0;
            off    <= 38'd0;
            state  <= (start_status == ST_OK) ? W_CK_RD : W_STAT;
          end
        end
        W_CK_RD: state <= W_CK_ENT;
        W_CK_ENT: begin
          if (tbl_rdata.ses != es_n || tbl_rdata.num != et_n) begin
            status <= ST_SEQUENCE;
            state  <= W_STAT;
          end else begin
            es    <= es_n;
            et    <= et_n + 10'd1;
            state <= W_CK_PG;
          end
        end
        W_CK_PG: begin
          off   <= off + {6'd0, prod};
          state <= W_CK_SC;
        end
        W_CK_SC: begin
          off   <= off + {6'd0, prod};
          i     <= i + TC_W'(1);
          state <= last_entry ? W_CK_END : W_CK_RD;
        end
        W_CK_END: begin
          if ({1'b0, sessions} < {1'b0, es} + 8'd1 || {1'b0, sessions} > {1'b0, es} + 8'd2) begin
            status <= ST_SESSIONS;
            state  <= W_STAT;
          end else if (off != {7'd0, header_position}) begin
            status <= ST_EXTENT;
            state  <= W_STAT;
          end else begin
            off   <= 38'd0;
            i     <= '0;
            state <= W_EM_RD;
          end
        end
        W_EM_RD:  state <= W_EM_ENT;
        W_EM_ENT: state <= W_EM_PG;
        W_EM_PG: begin
          pgb   <= prod;
          state <= W_EM_SC;
        end
        W_EM_SC: begin
          packed_sz <= prod;
          state     <= W_EM_OPG;
        end
        W_EM_OPG: begin
          if (pgb == 32'd0) begin
            state <= W_EM_OTR;
          end else if (push_ready) begin
            off   <= off + {6'd0, pgb};
            state <= W_EM_OTR;
          end
        end
        W_EM_OTR: begin
          if (push_ready) begin
            off   <= off + {6'd0, packed_sz};
            i     <= i + TC_W'(1);
            state <= last_entry ? W_STAT : W_EM_RD;
          end
        end
        W_STAT: begin
          if (push_ready) begin
            state <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end
endmodule
